/* src/pcent_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcent_pkg: shared constants for the polygon centroid block
// Accumulator widths, parameter defaults and result method codes.
// ----------------------------------------------------------------------------
package pcent_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int MAX_POINTS_DEF  = 1024;

  // Twice-area sum (Q.0) and centroid sums (Q.0), wrapping two's complement
  localparam int AREA_W = 43;
  localparam int CENT_W = 59;
  // 3 * area_sum
  localparam int DEN_W  = AREA_W + 2;

  localparam logic [1:0] METHOD_POINT = 2'd0;
  localparam logic [1:0] METHOD_MID   = 2'd1;
  localparam logic [1:0] METHOD_AREA  = 2'd2;
  localparam logic [1:0] METHOD_BOX   = 2'd3;

endpackage

/* src/pcent_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcent_div: iterative signed divider for the centroid quotient
// Computes num / (3 * area), truncated toward zero, one quotient bit per
// cycle, and saturates the result to the coordinate range.
// ----------------------------------------------------------------------------
module pcent_div #(
  parameter int CW = pcent_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [pcent_pkg::CENT_W-1:0] num,
  input  logic signed [pcent_pkg::AREA_W-1:0] area,
  output logic                                done,
  output logic signed [CW-1:0]                quo
);

  localparam int NUM_W = pcent_pkg::CENT_W;
  localparam int DEN_W = pcent_pkg::DEN_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic [NUM_W-1:0] Q_HI     = NUM_W'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [NUM_W-1:0] Q_LO_MAG = NUM_W'(64'd1 << (CW - 1));
  localparam logic [CW-1:0]    C_LO     = CW'(64'd1 << (CW - 1));

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_RUN  = 2'd1;
  localparam logic [1:0] DV_SAT  = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [NUM_W-1:0]        nq_r, nq_nxt;     // dividend shifts out, quotient shifts in
  logic [DEN_W-1:0]        rem_r, rem_nxt;
  logic [DEN_W-1:0]        dm_r, dm_nxt;
  logic                    neg_r, neg_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;
  logic signed [CW-1:0]    quo_r, quo_nxt;

  logic signed [DEN_W-1:0] den;
  logic [DEN_W:0]          trial;
  logic                    ge;
  logic [NUM_W-1:0]        negq;

  always_comb begin
    den   = (DEN_W'(area) <<< 1) + DEN_W'(area);
    trial = {rem_r, nq_r[NUM_W-1]};
    ge    = (trial >= {1'b0, dm_r});
    negq  = NUM_W'(0) - nq_r;

    state_nxt = state_r;
    nq_nxt    = nq_r;
    rem_nxt   = rem_r;
    dm_nxt    = dm_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    done_nxt  = 1'b0;

    case (state_r)
      DV_IDLE: begin
        if (start) begin
          neg_nxt   = num[NUM_W-1] ^ den[DEN_W-1];
          nq_nxt    = num[NUM_W-1] ? NUM_W'(~num + 1'b1) : NUM_W'(num);
          dm_nxt    = den[DEN_W-1] ? DEN_W'(~den + 1'b1) : DEN_W'(den);
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(NUM_W);
          state_nxt = DV_RUN;
        end
      end
      DV_RUN: begin
        rem_nxt = ge ? DEN_W'(trial - {1'b0, dm_r}) : DEN_W'(trial);
        nq_nxt  = {nq_r[NUM_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = DV_SAT;
        end
      end
      DV_SAT: begin
        if (!neg_r) begin
          quo_nxt = (nq_r > Q_HI) ? CW'(Q_HI) : nq_r[CW-1:0];
        end else begin
          quo_nxt = (nq_r > Q_LO_MAG) ? C_LO : negq[CW-1:0];
        end
        done_nxt  = 1'b1;
        state_nxt = DV_IDLE;
      end
      default: begin
        state_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nq_r  <= nq_nxt;
    rem_r <= rem_nxt;
    dm_r  <= dm_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* src/polygon_centroid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_centroid: shoelace area centroid of one polygon
// Accumulates cross products and centroid sums per vertex on one shared
// multiplier, then divides the sums by three times the area.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                      | tuser               | tlast
//  in_     | in  | pt_x [CW-1:0], pt_y above  | -                   | last
//  out_    | out | center_x, center_y above   | method[1:0], too_many[2] | -
//
// A vertex after the first goes through accept, bookkeeping and 8 multiplier
// steps; the first vertex and any ignored one take accept and bookkeeping only.
// Closing a ring of three or more adds a finish step, the closing edge (8), one
// area check, two bit-serial divides if the area is nonzero, then a hand-off.
// in_tready is high only while idle; a finished result waits in the output
// register while the next polygon accumulates. Reset is synchronous, clears sums.
// ----------------------------------------------------------------------------
module polygon_centroid #(
  parameter int MAX_POINTS  = pcent_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pcent_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,   // pt_x, pt_y
  input  logic                                   in_tlast,   // last
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     out_tdata,  // center_x, center_y
  output logic [2:0]                             out_tuser   // method, too_many
);

  localparam int CW     = COORD_WIDTH;
  localparam int DW     = ((2 * CW + 7) / 8) * 8;
  localparam int MW     = CW + 2;          // multiplier operand width
  localparam int PW     = 2 * MW;
  localparam int CR_W   = 2 * CW + 1;      // exact cross product
  localparam int AREA_W = pcent_pkg::AREA_W;
  localparam int CENT_W = pcent_pkg::CENT_W;
  localparam int XA_W   = (CR_W > AREA_W) ? CR_W : AREA_W;
  localparam int XC_W   = (PW + CW > CENT_W) ? PW + CW : CENT_W;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_VTX  = 4'd1;
  localparam logic [3:0] ST_E1   = 4'd2;
  localparam logic [3:0] ST_E2   = 4'd3;
  localparam logic [3:0] ST_E3   = 4'd4;
  localparam logic [3:0] ST_E4   = 4'd5;
  localparam logic [3:0] ST_E5   = 4'd6;
  localparam logic [3:0] ST_E6   = 4'd7;
  localparam logic [3:0] ST_E7   = 4'd8;
  localparam logic [3:0] ST_E8   = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;
  localparam logic [3:0] ST_AREA = 4'd11;
  localparam logic [3:0] ST_DX   = 4'd12;
  localparam logic [3:0] ST_DY   = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  function automatic logic signed [CW-1:0] half_sum(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    return s[CW:1];
  endfunction

  logic [3:0]                state_r, state_nxt;
  logic signed [CW-1:0]      cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic                      last_r, last_nxt;
  logic signed [CW-1:0]      first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic signed [CW-1:0]      prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [CW-1:0]      bmin_x_r, bmin_x_nxt, bmin_y_r, bmin_y_nxt;
  logic signed [CW-1:0]      bmax_x_r, bmax_x_nxt, bmax_y_r, bmax_y_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      closing_r, closing_nxt;
  logic signed [AREA_W-1:0]  area_r, area_nxt;
  logic signed [CENT_W-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [PW-1:0]      prod_r, prod_nxt;
  logic signed [CR_W-1:0]    cr_r, cr_nxt;
  logic signed [CW-1:0]      res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic [1:0]                res_m_r, res_m_nxt;
  logic signed [CW-1:0]      out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [1:0]                out_m_r, out_m_nxt;
  logic                      out_too_r, out_too_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic signed [CW-1:0]      bx, by;
  logic signed [CW:0]        sx, sy;
  logic signed [MW-1:0]      mul_a, mul_b, lo_op, hi_op;
  logic signed [CR_W-1:0]    cr_diff;
  logic signed [XC_W-1:0]    pe;

  logic                      div_start, div_done;
  logic signed [CENT_W-1:0]  div_num;
  logic signed [CW-1:0]      div_quo;

  pcent_div #(
    .CW (CW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .area  (area_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Shared multiplier: operand select by sequencer step
  always_comb begin
    bx      = closing_r ? first_x_r : cur_x_r;
    by      = closing_r ? first_y_r : cur_y_r;
    sx      = (CW+1)'(prev_x_r) + (CW+1)'(bx);
    sy      = (CW+1)'(prev_y_r) + (CW+1)'(by);
    lo_op   = MW'({1'b0, cr_r[CW-1:0]});
    hi_op   = MW'($signed(cr_r[CR_W-1:CW]));
    cr_diff = cr_r - CR_W'(prod_r);
    pe      = XC_W'(prod_r);
    case (state_r)
      ST_E2: begin
        mul_a = MW'(prev_y_r);
        mul_b = MW'(bx);
      end
      ST_E4: begin
        mul_a = MW'(sx);
        mul_b = lo_op;
      end
      ST_E5: begin
        mul_a = MW'(sx);
        mul_b = hi_op;
      end
      ST_E6: begin
        mul_a = MW'(sy);
        mul_b = lo_op;
      end
      ST_E7: begin
        mul_a = MW'(sy);
        mul_b = hi_op;
      end
      default: begin
        mul_a = MW'(prev_x_r);
        mul_b = MW'(by);
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    last_nxt      = last_r;
    first_x_nxt   = first_x_r;
    first_y_nxt   = first_y_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    bmin_x_nxt    = bmin_x_r;
    bmin_y_nxt    = bmin_y_r;
    bmax_x_nxt    = bmax_x_r;
    bmax_y_nxt    = bmax_y_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    closing_nxt   = closing_r;
    area_nxt      = area_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cr_nxt        = cr_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_m_nxt     = res_m_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_m_nxt     = out_m_r;
    out_too_nxt   = out_too_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    div_num       = cx_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cur_x_nxt = in_tdata[CW-1:0];
          cur_y_nxt = in_tdata[2*CW-1:CW];
          last_nxt  = in_tlast;
          state_nxt = ST_VTX;
        end
      end
      ST_VTX: begin
        if (cnt_r >= CNT_W'(MAX_POINTS)) begin
          ovf_nxt   = 1'b1;
          state_nxt = last_r ? ST_FIN : ST_IDLE;
        end else if (cnt_r == '0) begin
          first_x_nxt = cur_x_r;
          first_y_nxt = cur_y_r;
          prev_x_nxt  = cur_x_r;
          prev_y_nxt  = cur_y_r;
          bmin_x_nxt  = cur_x_r;
          bmax_x_nxt  = cur_x_r;
          bmin_y_nxt  = cur_y_r;
          bmax_y_nxt  = cur_y_r;
          cnt_nxt     = CNT_W'(1);
          state_nxt   = last_r ? ST_FIN : ST_IDLE;
        end else begin
          if (cur_x_r < bmin_x_r) bmin_x_nxt = cur_x_r;
          if (cur_x_r > bmax_x_r) bmax_x_nxt = cur_x_r;
          if (cur_y_r < bmin_y_r) bmin_y_nxt = cur_y_r;
          if (cur_y_r > bmax_y_r) bmax_y_nxt = cur_y_r;
          closing_nxt = 1'b0;
          state_nxt   = ST_E1;
        end
      end
      ST_E1: state_nxt = ST_E2;
      ST_E2: begin
        cr_nxt    = CR_W'(prod_r);
        state_nxt = ST_E3;
      end
      ST_E3: begin
        cr_nxt    = cr_diff;
        area_nxt  = area_r + AREA_W'(XA_W'(cr_diff));
        state_nxt = ST_E4;
      end
      ST_E4: state_nxt = ST_E5;
      ST_E5: begin
        cx_nxt    = cx_r + CENT_W'(pe);
        state_nxt = ST_E6;
      end
      ST_E6: begin
        cx_nxt    = cx_r + CENT_W'(pe <<< CW);
        state_nxt = ST_E7;
      end
      ST_E7: begin
        cy_nxt    = cy_r + CENT_W'(pe);
        state_nxt = ST_E8;
      end
      ST_E8: begin
        cy_nxt = cy_r + CENT_W'(pe <<< CW);
        if (closing_r) begin
          state_nxt = ST_AREA;
        end else begin
          prev_x_nxt = cur_x_r;
          prev_y_nxt = cur_y_r;
          cnt_nxt    = cnt_r + 1'b1;
          state_nxt  = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (cnt_r <= CNT_W'(1)) begin
          res_x_nxt = first_x_r;
          res_y_nxt = first_y_r;
          res_m_nxt = pcent_pkg::METHOD_POINT;
          state_nxt = ST_OUT;
        end else if (cnt_r == CNT_W'(2)) begin
          res_x_nxt = half_sum(first_x_r, prev_x_r);
          res_y_nxt = half_sum(first_y_r, prev_y_r);
          res_m_nxt = pcent_pkg::METHOD_MID;
          state_nxt = ST_OUT;
        end else begin
          // close the ring: edge from last accepted vertex back to the first
          closing_nxt = 1'b1;
          state_nxt   = ST_E1;
        end
      end
      ST_AREA: begin
        if (area_r == '0) begin
          res_x_nxt = half_sum(bmin_x_r, bmax_x_r);
          res_y_nxt = half_sum(bmin_y_r, bmax_y_r);
          res_m_nxt = pcent_pkg::METHOD_BOX;
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DX;
        end
      end
      ST_DX: begin
        div_num = cy_r;
        if (div_done) begin
          res_x_nxt = div_quo;
          div_start = 1'b1;
          state_nxt = ST_DY;
        end
      end
      ST_DY: begin
        if (div_done) begin
          res_y_nxt = div_quo;
          res_m_nxt = pcent_pkg::METHOD_AREA;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_x_nxt     = res_x_r;
          out_y_nxt     = res_y_r;
          out_m_nxt     = res_m_r;
          out_too_nxt   = ovf_r;
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
          closing_nxt   = 1'b0;
          area_nxt      = '0;
          cx_nxt        = '0;
          cy_nxt        = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      closing_r   <= 1'b0;
      area_r      <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      closing_r   <= closing_nxt;
      area_r      <= area_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r   <= cur_x_nxt;
    cur_y_r   <= cur_y_nxt;
    last_r    <= last_nxt;
    first_x_r <= first_x_nxt;
    first_y_r <= first_y_nxt;
    prev_x_r  <= prev_x_nxt;
    prev_y_r  <= prev_y_nxt;
    bmin_x_r  <= bmin_x_nxt;
    bmin_y_r  <= bmin_y_nxt;
    bmax_x_r  <= bmax_x_nxt;
    bmax_y_r  <= bmax_y_nxt;
    prod_r    <= prod_nxt;
    cr_r      <= cr_nxt;
    res_x_r   <= res_x_nxt;
    res_y_r   <= res_y_nxt;
    res_m_r   <= res_m_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_m_r   <= out_m_nxt;
    out_too_r <= out_too_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = DW'({out_y_r, out_x_r});
  assign out_tuser  = {out_too_r, out_m_r};

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for polygon_centroid
// Streams polygons of random length, coordinate spread and closing mark into
// the block under bursty input timing and a stalling result side. A model of
// the shoelace centroid predicts each result, and every returned transaction
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int CW       = pcent_pkg::COORD_WIDTH_DEF;
  localparam int MAXP     = pcent_pkg::MAX_POINTS_DEF;
  localparam int DW       = ((2 * CW + 7) / 8) * 8;
  localparam int RAND_CNT = 500;
  localparam int QUIET_LIMIT = 4000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [1:0]    how;
    logic          many;
  } center_t;

  typedef enum int {SPREAD_FULL, SPREAD_TIGHT, SPREAD_CORNERS, SPREAD_CLUSTER} spread_t;

  // Running shoelace sums of the open polygon plus the queue of predicted centers
  class centroid_book;
    coord_t             first_x, first_y, prev_x, prev_y;
    coord_t             lo_x, lo_y, hi_x, hi_y;
    int unsigned        n_vert;
    logic signed [pcent_pkg::AREA_W-1:0] area_acc;
    logic signed [pcent_pkg::CENT_W-1:0] csum_x, csum_y;
    bit                 dropped;
    center_t            pending[$];
    int                 errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      first_x = '0; first_y = '0; prev_x = '0; prev_y = '0;
      lo_x = '0; lo_y = '0; hi_x = '0; hi_y = '0;
      n_vert = 0;
      area_acc = '0; csum_x = '0; csum_y = '0;
      dropped = 1'b0;
    endfunction

    function void add_edge(longint ax, longint ay, longint bx, longint by);
      longint cr;
      cr = ax * by - ay * bx;
      area_acc = area_acc + pcent_pkg::AREA_W'(cr);
      csum_x = csum_x + pcent_pkg::CENT_W'((ax + bx) * cr);
      csum_y = csum_y + pcent_pkg::CENT_W'((ay + by) * cr);
    endfunction

    function longint clamp(longint v);
      longint hi, lo;
      hi = (longint'(1) << (CW - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // truncating divide, magnitude capped before the clamp
    function longint div_sat(longint num, longint den);
      longint unsigned n, d, q, cap;
      bit neg;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = n / d;
      cap = longint'(1) << CW;
      if (q > cap) q = cap;
      return clamp(neg ? -longint'(q) : longint'(q));
    endfunction

    function void take_vertex(coord_t x, coord_t y, bit is_last);
      longint cx, cy, den;
      logic [1:0] how;
      center_t c;
      if (n_vert >= MAXP) begin
        dropped = 1'b1;
      end else begin
        if (n_vert == 0) begin
          first_x = x; first_y = y;
          lo_x = x; hi_x = x; lo_y = y; hi_y = y;
        end else begin
          add_edge(prev_x, prev_y, x, y);
          if (x < lo_x) lo_x = x;
          if (x > hi_x) hi_x = x;
          if (y < lo_y) lo_y = y;
          if (y > hi_y) hi_y = y;
        end
        prev_x = x; prev_y = y;
        n_vert++;
      end
      if (!is_last) return;

      if (n_vert <= 1) begin
        cx = first_x; cy = first_y; how = pcent_pkg::METHOD_POINT;
      end else if (n_vert == 2) begin
        cx = (longint'(first_x) + prev_x) >>> 1;
        cy = (longint'(first_y) + prev_y) >>> 1;
        how = pcent_pkg::METHOD_MID;
      end else begin
        add_edge(prev_x, prev_y, first_x, first_y);
        if (area_acc != 0) begin
          den = 3 * longint'(area_acc);
          cx = div_sat(csum_x, den);
          cy = div_sat(csum_y, den);
          how = pcent_pkg::METHOD_AREA;
        end else begin
          cx = (longint'(lo_x) + hi_x) >>> 1;
          cy = (longint'(lo_y) + hi_y) >>> 1;
          how = pcent_pkg::METHOD_BOX;
        end
      end
      c.cx = CW'(clamp(cx));
      c.cy = CW'(clamp(cy));
      c.how = how;
      c.many = dropped;
      pending.push_back(c);
      clear();
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function void compare_center(logic [CW-1:0] gx, logic [CW-1:0] gy,
                                 logic [1:0] gm, logic gt);
      center_t want;
      if (pending.size() == 0) begin
        note_error($sformatf("unexpected result x=%0d y=%0d method=%0d too_many=%0d",
                             $signed(gx), $signed(gy), gm, gt));
        return;
      end
      want = pending.pop_front();
      if (gx !== want.cx || gy !== want.cy || gm !== want.how || gt !== want.many)
        note_error($sformatf("exp x=%0d y=%0d m=%0d tm=%0d, got x=%0d y=%0d m=%0d tm=%0d",
                             $signed(want.cx), $signed(want.cy), want.how, want.many,
                             $signed(gx), $signed(gy), gm, gt));
    endfunction
  endclass

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_tvalid  = 1'b0;
  logic          in_tready;
  logic [DW-1:0] in_tdata   = '0;
  logic          in_tlast   = 1'b0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [DW-1:0] out_tdata;
  logic [2:0]    out_tuser;

  centroid_book book = new();
  int burst_left = 0;
  int n_sent = 0;
  int quiet = 0;
  int rx_cycle = 0;
  int ready_pct = 100;

  polygon_centroid DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // sender: bursts of random length separated by random gaps
  task automatic send_vertex(input coord_t x, input coord_t y, input bit is_last);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DW'({y, x});
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    book.take_vertex(x, y, is_last);
    burst_left--;
    n_sent++;
  endtask

  // drop valid and hold off until every predicted center has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (book.pending.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic coord_t pick_coord(spread_t spread, int base);
    case (spread)
      SPREAD_FULL:  return CW'($urandom);
      SPREAD_TIGHT: return CW'(int'($urandom_range(0, 32)) - 16);
      SPREAD_CORNERS: begin
        case ($urandom_range(0, 5))
          0:       return coord_t'(-32768);
          1:       return coord_t'(32767);
          2:       return '0;
          3:       return coord_t'(-1);
          4:       return coord_t'(1);
          default: return coord_t'(-32767);
        endcase
      end
      default: return CW'(base + int'($urandom_range(0, 15)));
    endcase
  endfunction

  task automatic send_polygon(input int nv, input spread_t spread);
    int bx, by;
    bx = int'($urandom_range(0, 65535)) - 32768;
    by = int'($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < nv; i++)
      send_vertex(pick_coord(spread, bx), pick_coord(spread, by), i == nv - 1);
  endtask

  // result side: stall pattern switches among 100, 70 and 25 percent ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      book.compare_center(out_tdata[CW-1:0], out_tdata[2*CW-1:CW],
                          out_tuser[1:0], out_tuser[2]);
    rx_cycle++;
    if (rx_cycle % 200 == 0) begin
      case ($urandom_range(0, 2))
        0:       ready_pct = 100;
        1:       ready_pct = 70;
        default: ready_pct = 25;
      endcase
    end
    out_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int nv, pick, rand_start, polys;
    spread_t spread;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single points at the coordinate extremes
    send_vertex(-32768, -32768, 1'b1);
    send_vertex(32767, 32767, 1'b1);
    // midpoints, one rounding down below zero
    send_vertex(32767, 32767, 1'b0);
    send_vertex(-32768, -32768, 1'b1);
    send_vertex(1, 0, 1'b0);
    send_vertex(2, 3, 1'b1);
    // triangles of both windings
    send_vertex(0, 0, 1'b0);
    send_vertex(160, 0, 1'b0);
    send_vertex(0, 160, 1'b1);
    send_vertex(0, 0, 1'b0);
    send_vertex(0, 160, 1'b0);
    send_vertex(160, 0, 1'b1);
    // zero area: collinear, then a repeated point
    send_vertex(-3, -3, 1'b0);
    send_vertex(0, 0, 1'b0);
    send_vertex(2, 2, 1'b1);
    send_vertex(-32768, 32767, 1'b0);
    send_vertex(-32768, 32767, 1'b0);
    send_vertex(-32768, 32767, 1'b1);
    // full-range square and a lopsided bow tie
    send_vertex(-32768, -32768, 1'b0);
    send_vertex(32767, -32768, 1'b0);
    send_vertex(32767, 32767, 1'b0);
    send_vertex(-32768, 32767, 1'b1);
    send_vertex(-32768, -32768, 1'b0);
    send_vertex(32767, 32767, 1'b0);
    send_vertex(32767, -32767, 1'b0);
    send_vertex(-32768, 32767, 1'b1);

    // exactly the vertex limit, then past it with the mark on an ignored vertex
    send_polygon(MAXP, SPREAD_FULL);
    drain_results();
    send_polygon(MAXP + 2, SPREAD_CLUSTER);

    rand_start = n_sent;
    polys = 0;
    while (n_sent < rand_start + RAND_CNT) begin
      pick = $urandom_range(0, 19);
      if (pick < 2)       nv = 1;
      else if (pick < 4)  nv = 2;
      else if (pick == 19) nv = $urandom_range(13, 40);
      else                nv = $urandom_range(3, 12);
      spread = spread_t'($urandom_range(0, 3));
      send_polygon(nv, spread);
      polys++;
      if (polys == 25) drain_results();
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* polygon_centroid.f */
src/pcent_pkg.sv
src/pcent_div.sv
src/polygon_centroid.sv
dv/tb.sv
